// ===== design/hsv2rgb_pkg.sv =====
// shared constants and helpers for the hsv to rgb converter
package hsv2rgb_pkg;

    localparam int unsigned PIPE_DEPTH = 4;

    typedef logic [2:0] t_sext;
    typedef logic [7:0] t_chan;

    localparam t_sext SEXT_LAST = 3'd5;
    localparam t_chan CHAN_MAX  = 8'hff;

    // hue sextants 6 and 7 fold onto the last one
    function automatic t_sext clamp_sext(input t_sext sext);
        t_sext res;
        res = (sext > SEXT_LAST) ? SEXT_LAST : sext;
        return res;
    endfunction

    // correction step: w + (w >> 8) kept to 16 bits, then the high byte
    function automatic t_chan corr_hi(input logic [15:0] w);
        logic [16:0] sum;
        sum = {1'b0, w} + {9'd0, w[15:8]};
        return sum[15:8];
    endfunction

endpackage

// ===== design/hsv_to_rgb_8bit_unit.sv =====
// hsv to rgb pixel converter, four register stages, one request per clock
// an accepted request passes through r_vld1 to r_vld4 in turn and shows on o_valid from r_vld4
// throughput: one request every clock, the receiver cannot stall so busy stays low in operation
// stage one registers the request, stage two the two products, stage three the corrections,
// stage four the slope multiply and routing; reset: synchronous active low i_rst_n clears the
// valid pipeline; busy is high until the first clock after reset is released
module hsv_to_rgb_8bit_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [10:0] i_hue,
    input  logic [7:0]  i_saturation,
    input  logic [7:0]  i_brightness,
    output logic        o_valid,
    output logic [7:0]  o_red,
    output logic [7:0]  o_green,
    output logic [7:0]  o_blue
);

    logic w_accept;
    logic r_ready;

    // stage 1: captured request
    logic                 r_vld1;
    hsv2rgb_pkg::t_sext   r_sext1;
    logic [7:0]           r_f1;
    logic [7:0]           r_s1;
    logic [7:0]           r_v1;

    // stage 2: raw products
    logic                 r_vld2;
    hsv2rgb_pkg::t_sext   r_sext2;
    logic                 r_grey2;
    logic [7:0]           r_v2;
    logic [15:0]          r_wb2;
    logic [15:0]          r_ws2;
    logic [15:0]          n_wb2;
    logic [15:0]          n_ws2;
    logic [8:0]           w_rise;

    // stage 3: bottom level and slope factor
    logic                 r_vld3;
    hsv2rgb_pkg::t_sext   r_sext3;
    logic                 r_grey3;
    logic [7:0]           r_v3;
    logic [7:0]           r_bot3;
    logic [7:0]           r_k3;

    // stage 4: channel outputs
    logic                 r_vld4;
    logic [7:0]           r_red4;
    logic [7:0]           r_grn4;
    logic [7:0]           r_blu4;
    logic [15:0]          w_slope_w;
    logic [7:0]           w_slope;
    logic [7:0]           n_red4;
    logic [7:0]           n_grn4;
    logic [7:0]           n_blu4;

    function automatic logic is_odd_sext(input hsv2rgb_pkg::t_sext sext);
        return sext[0];
    endfunction

    assign busy     = ~r_ready;
    assign w_accept = start & ~busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ready <= 1'b0;
            r_vld1  <= 1'b0;
            r_vld2  <= 1'b0;
            r_vld3  <= 1'b0;
            r_vld4  <= 1'b0;
        end else begin
            r_ready <= 1'b1;
            r_vld1  <= w_accept;
            r_vld2  <= r_vld1;
            r_vld3  <= r_vld2;
            r_vld4  <= r_vld3;
        end
    end

    // stage 1
    always_ff @(posedge i_clk) begin
        r_sext1 <= hsv2rgb_pkg::clamp_sext(i_hue[10:8]);
        r_f1    <= i_hue[7:0];
        r_s1    <= i_saturation;
        r_v1    <= i_brightness;
    end

    // stage 2: 256 - f also covers f == 0, giving s * 256
    always_comb begin
        w_rise = 9'd256 - {1'b0, r_f1};
        n_wb2  = 16'(r_v1 * (hsv2rgb_pkg::CHAN_MAX - r_s1)) + 16'd1;
        if (is_odd_sext(r_sext1)) begin
            n_ws2 = 16'(r_s1 * r_f1);
        end else begin
            n_ws2 = 16'(r_s1 * w_rise);
        end
    end

    always_ff @(posedge i_clk) begin
        r_sext2 <= r_sext1;
        r_grey2 <= (r_s1 == 8'd0);
        r_v2    <= r_v1;
        r_wb2   <= n_wb2;
        r_ws2   <= n_ws2;
    end

    // stage 3
    always_ff @(posedge i_clk) begin
        r_sext3 <= r_sext2;
        r_grey3 <= r_grey2;
        r_v3    <= r_v2;
        r_bot3  <= hsv2rgb_pkg::corr_hi(r_wb2);
        r_k3    <= hsv2rgb_pkg::CHAN_MAX - hsv2rgb_pkg::corr_hi(r_ws2);
    end

    // stage 4: slope level with rounding, then channel routing
    always_comb begin
        w_slope_w = 16'(r_v3 * r_k3) + {9'd0, r_v3[7:1]};
        w_slope   = w_slope_w[15:8];
        n_red4    = r_v3;
        n_grn4    = r_v3;
        n_blu4    = r_v3;
        if (!r_grey3) begin
            case (r_sext3)
                3'd0: begin
                    n_red4 = r_v3;    n_grn4 = w_slope; n_blu4 = r_bot3;
                end
                3'd1: begin
                    n_red4 = w_slope; n_grn4 = r_v3;    n_blu4 = r_bot3;
                end
                3'd2: begin
                    n_red4 = r_bot3;  n_grn4 = r_v3;    n_blu4 = w_slope;
                end
                3'd3: begin
                    n_red4 = r_bot3;  n_grn4 = w_slope; n_blu4 = r_v3;
                end
                3'd4: begin
                    n_red4 = w_slope; n_grn4 = r_bot3;  n_blu4 = r_v3;
                end
                default: begin
                    n_red4 = r_v3;    n_grn4 = r_bot3;  n_blu4 = w_slope;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_red4 <= n_red4;
        r_grn4 <= n_grn4;
        r_blu4 <= n_blu4;
    end

    assign o_valid = r_vld4;
    assign o_red   = r_red4;
    assign o_green = r_grn4;
    assign o_blue  = r_blu4;

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> ##4 o_valid)
        else $error("request did not reach the output after four cycles");

    a_no_extra: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_accept |-> ##4 !o_valid)
        else $error("output strobe without a matching request");

    a_grey: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_saturation == 8'd0) |-> ##4
        (o_red == $past(i_brightness, 4) && o_green == $past(i_brightness, 4)
         && o_blue == $past(i_brightness, 4)))
        else $error("grey pixel channels differ from brightness");

    a_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> ##4
        (o_red == $past(i_brightness, 4) || o_green == $past(i_brightness, 4)
         || o_blue == $past(i_brightness, 4)))
        else $error("no channel carries the brightness");

endmodule
